FILE: hw/rtl/bust_pkg.sv
// Package for the bounded unique set table: capacity, widths, codes and shared types.
// Used by the top level, the sequencer and the checker; depends on nothing.
package bust_pkg;

	localparam int CAPACITY_ENTRIES = 32;
	localparam int VALUE_W = 32;
	localparam int IDX_W = $clog2(CAPACITY_ENTRIES);
	localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);
	localparam int COUNT_OUT_W = 6;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_PRESENT   = 3'd5,
		ST_ABSENT    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_MOVE,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t                  status;
		logic                     present;
		logic [COUNT_OUT_W-1:0]   count;
	} result_t;

	typedef struct packed {
		logic                 we;
		logic [IDX_W-1:0]     waddr;
		logic [VALUE_W-1:0]   wdata;
		logic [IDX_W-1:0]     raddr;
	} ram_req_t;

endpackage

FILE: hw/rtl/bounded_unique_set_table_core.sv
// Top level of the bounded unique set table: sequencer, entry RAM and output register.
// Depends on bust_pkg, bust_ram and bust_engine.
//
// The block holds up to CAPACITY_ENTRIES distinct 32-bit signed values and a count.
// Each input word (opcode, value) is one operation: add, remove or query; an
// unused opcode acts as a query. Each operation yields exactly one output word
// (status, present, count), where count is the number of entries afterward.
// Both channels use valid and ready. The input is taken only while the sequencer
// is idle; one comparator checks one stored entry per cycle from the RAM's
// registered read port, stopping at the first match or at the count.
// After acceptance the sequencer scans the stored entries (no scan when the table
// is empty), then executes the operation, then, for a remove that found its value,
// moves the last entry into the freed slot, and then offers the result to the output
// register; it returns to idle before the next input word is taken. The output
// register holds a finished word while the receiver stalls, and the sequencer may
// accept and process the next word meanwhile; it waits only when it has a second
// result and the output register is still full.
// Reset empties the table at once; the RAM contents are left as they are.
module bounded_unique_set_table_core
	import bust_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 opcode,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic                       present,
	output logic [COUNT_OUT_W-1:0]     count
);

	ram_req_t             ram_req;
	logic [VALUE_W-1:0]   ram_rdata;
	logic                 res_valid;
	logic                 res_take;
	result_t              res;
	logic                 out_valid_q;
	result_t              out_res_q;

	assign res_take = res_valid && (!out_valid_q || out_ready);

	bust_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.value     (value),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	bust_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_res_q.status;
	assign present = out_res_q.present;
	assign count = out_res_q.count;

endmodule

FILE: hw/rtl/bust_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/bust_engine.sv
// Sequencer of the set table: scans the stored entries through one comparator,
// then appends, moves the last entry or only reports. Depends on bust_pkg.
module bust_engine
	import bust_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [VALUE_W-1:0]   value,
	output ram_req_t             ram_req,
	input  logic [VALUE_W-1:0]   ram_rdata,
	output logic                 res_valid,
	input  logic                 res_take,
	output result_t              res
);

	state_t               state_q;
	state_t               state_d;
	opcode_t              op_q;
	logic [VALUE_W-1:0]   value_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 found_q;
	logic [CNT_W-1:0]     count_q;
	status_t              status_q;

	logic                 hit;
	logic                 scan_last;
	logic                 table_full;
	logic                 do_append;
	logic [CNT_W-1:0]     last_cnt;
	status_t              exec_status;

	assign hit = (ram_rdata == value_q);
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign table_full = (count_q == CNT_W'(CAPACITY_ENTRIES));
	assign do_append = (op_q == OP_ADD) && !found_q && !table_full;
	assign last_cnt = count_q - CNT_W'(1);

	always_comb begin
		case (op_q)
			OP_ADD: begin
				if (found_q) begin
					exec_status = ST_DUPLICATE;
				end else if (table_full) begin
					exec_status = ST_FULL;
				end else begin
					exec_status = ST_ADDED;
				end
			end
			OP_REMOVE: begin
				exec_status = found_q ? ST_REMOVED : ST_NOT_FOUND;
			end
			default: begin
				exec_status = found_q ? ST_PRESENT : ST_ABSENT;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (count_q == '0) ? S_EXEC : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = (op_q == OP_REMOVE && found_q) ? S_MOVE : S_DONE;
			end
			S_MOVE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		res_valid = 1'b0;
		ram_req.we = 1'b0;
		ram_req.waddr = count_q[IDX_W-1:0];
		ram_req.wdata = value_q;
		ram_req.raddr = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SCAN: begin
				ram_req.raddr = idx_q + IDX_W'(1);
			end
			S_EXEC: begin
				ram_req.we = do_append;
				ram_req.raddr = last_cnt[IDX_W-1:0];
			end
			S_MOVE: begin
				ram_req.we = 1'b1;
				ram_req.waddr = slot_q;
				ram_req.wdata = ram_rdata;
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				S_EXEC: begin
					if (do_append) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_MOVE: begin
					count_q <= last_cnt;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q <= opcode_t'(opcode);
					value_q <= value;
					idx_q <= '0;
				end
			end
			S_SCAN: begin
				if (hit) begin
					slot_q <= idx_q;
				end else if (!scan_last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_EXEC: begin
				status_q <= exec_status;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign res.status = status_q;
	assign res.present = found_q;
	assign res.count = COUNT_OUT_W'(count_q);

endmodule

FILE: hw/rtl/bust_checker.sv
// Port-level checker for the bounded unique set table, bound to the top level.
// Depends on bust_pkg and bounded_unique_set_table_core.
module bust_checker
	import bust_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [2:0]                 status,
	input logic                       present,
	input logic [COUNT_OUT_W-1:0]     count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(present)
			&& $stable(count))
		else $error("Stalled output word changed or dropped.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken again right after an accepted word.");

	a_new_not_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ADDED || status == ST_NOT_FOUND || status == ST_ABSENT
			|| status == ST_FULL) |-> !present)
		else $error("Present flag set on a status that means absent.");

	a_found_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUPLICATE || status == ST_REMOVED
			|| status == ST_PRESENT) |-> present)
		else $error("Present flag clear on a status that means found.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count == COUNT_OUT_W'(CAPACITY_ENTRIES))
		else $error("Full status reported below capacity.");

endmodule

bind bounded_unique_set_table_core bust_checker u_bust_checker (.*);
